>>> rtl/core/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

   // One input transfer: a character and its end-of-string flag.
   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } req_type;

   // One result transfer: a data byte or the end-of-string summary.
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_summary;
      logic [1:0]  status;
      logic [15:0] byte_count;
      logic        last_result;
   } rsp_type;

   // Summary status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // The padding character.
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Outcome of the alphabet lookup.
   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   // Maps a character onto its 6-bit value in the standard alphabet.
   function automatic sextet_type map_char(input logic [7:0] c);
      sextet_type r;
      logic [7:0] t;
      r = '0;
      t = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         t = c - 8'h41;
         r.valid = 1'b1;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         t = c - 8'h47;
         r.valid = 1'b1;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         t = c + 8'h04;
         r.valid = 1'b1;
      end else if (c == 8'h2B) begin
         t = 8'd62;
         r.valid = 1'b1;
      end else if (c == 8'h2F) begin
         t = 8'd63;
         r.valid = 1'b1;
      end
      r.value = t[5:0];
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/base64_stream_decoder_core.sv
`default_nettype none

// Streaming base64 decoder. One character is accepted per clock cycle on
// the req_ channel unless req_stall is high; an accepted character is held
// in the input register, is decoded there, and its results enter a
// four-entry result queue, from whose head the oldest result is offered
// on rsp_.
// A character gives at most two results: a data byte and, when
// it is flagged last, the summary. The queue sets the rate: the input
// register moves on only while the queue holds two results or fewer, so a
// consumer that takes one result per cycle sees one character per cycle,
// except when the summary of a string adds a second result.
// The capacity register is written through csr_, which is always ready,
// and must only be written while no string is in flight.
module base64_stream_decoder_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire b64d_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output b64d_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [15:0]       csr_data
);

   // Input register.
   logic              in_valid_ff;
   b64d_pkg::req_type in_ff;

   // Decoder state.
   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  held_ff, held_in;
   logic        pad_ff, pad_in;
   logic [1:0]  err_ff, err_in;
   logic [15:0] bw_ff, bw_in;
   logic [15:0] cap_ff;

   // Result queue.
   b64d_pkg::rsp_type queue_ff [4];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] count_ff, count_in;

   // Decode results of the registered character.
   b64d_pkg::sextet_type mapped;
   logic [1:0]  phase_nx;
   logic [5:0]  held_nx;
   logic        pad_nx;
   logic [1:0]  err_nx;
   logic [15:0] bw_nx;
   logic        byte_due;
   logic        byte_ok;
   logic [7:0]  byte_val;
   b64d_pkg::rsp_type data_res;
   b64d_pkg::rsp_type sum_res;

   logic advance;
   logic pop;
   logic [1:0] push_n;

   // The stage moves on when the queue has room for two results.
   assign advance   = in_valid_ff && (count_ff <= 3'd2);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   assign rsp_valid   = (count_ff != 3'd0);
   assign rsp_payload = queue_ff[rd_ff];
   assign pop         = rsp_valid && !rsp_stall;

   // Decode one character and work out the state that follows.
   always_comb begin
      mapped   = b64d_pkg::map_char(in_ff.char_code);
      phase_nx = phase_ff;
      held_nx  = held_ff;
      pad_nx   = pad_ff;
      err_nx   = err_ff;
      bw_nx    = bw_ff;
      byte_due = 1'b0;
      byte_ok  = 1'b0;
      byte_val = 8'd0;
      if (err_ff == b64d_pkg::STATUS_OK) begin
         if (in_ff.char_code == b64d_pkg::PAD_CHAR) begin
            pad_nx = 1'b1;
         end else if (!mapped.valid || pad_ff) begin
            err_nx = b64d_pkg::STATUS_INVALID;
         end else begin
            case (phase_ff)
               2'd0: begin
                  held_nx  = mapped.value;
                  phase_nx = 2'd1;
               end
               2'd1: begin
                  byte_due = 1'b1;
                  byte_val = {held_ff, mapped.value[5:4]};
                  held_nx  = {2'b00, mapped.value[3:0]};
                  phase_nx = 2'd2;
               end
               2'd2: begin
                  byte_due = 1'b1;
                  byte_val = {held_ff[3:0], mapped.value[5:2]};
                  held_nx  = {4'b0000, mapped.value[1:0]};
                  phase_nx = 2'd3;
               end
               default: begin
                  byte_due = 1'b1;
                  byte_val = {held_ff[1:0], mapped.value};
                  held_nx  = 6'd0;
                  phase_nx = 2'd0;
               end
            endcase
         end
      end
      // A lone character at the end of the string still yields a byte.
      if (in_ff.last && err_nx == b64d_pkg::STATUS_OK && phase_nx == 2'd1) begin
         byte_due = 1'b1;
         byte_val = {held_nx, 2'b00};
      end
      // Capacity check on the byte that is due.
      if (byte_due) begin
         if (bw_ff >= cap_ff) begin
            err_nx = b64d_pkg::STATUS_OVERFLOW;
         end else begin
            byte_ok = 1'b1;
            bw_nx   = bw_ff + 16'd1;
         end
      end

      data_res.out_byte    = byte_val;
      data_res.is_summary  = 1'b0;
      data_res.status      = b64d_pkg::STATUS_OK;
      data_res.byte_count  = 16'd0;
      data_res.last_result = !in_ff.last;

      sum_res.out_byte    = 8'd0;
      sum_res.is_summary  = 1'b1;
      sum_res.status      = err_nx;
      sum_res.byte_count  = (err_nx == b64d_pkg::STATUS_OK) ? bw_nx : 16'd0;
      sum_res.last_result = 1'b1;

      // The end of a string returns everything to the start state.
      if (in_ff.last) begin
         phase_in = 2'd0;
         held_in  = 6'd0;
         pad_in   = 1'b0;
         err_in   = b64d_pkg::STATUS_OK;
         bw_in    = 16'd0;
      end else begin
         phase_in = phase_nx;
         held_in  = held_nx;
         pad_in   = pad_nx;
         err_in   = err_nx;
         bw_in    = bw_nx;
      end
   end

   // Queue pointer and fill bookkeeping.
   always_comb begin
      push_n   = 2'd0;
      if (advance) begin
         push_n = {1'b0, byte_ok} + {1'b0, in_ff.last};
      end
      wr_in    = wr_ff + push_n;
      rd_in    = rd_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, push_n} - {2'b00, pop};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= 2'd0;
         held_ff     <= 6'd0;
         pad_ff      <= 1'b0;
         err_ff      <= b64d_pkg::STATUS_OK;
         bw_ff       <= 16'd0;
         cap_ff      <= 16'hFFFF;
         wr_ff       <= 2'd0;
         rd_ff       <= 2'd0;
         count_ff    <= 3'd0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            phase_ff <= phase_in;
            held_ff  <= held_in;
            pad_ff   <= pad_in;
            err_ff   <= err_in;
            bw_ff    <= bw_in;
         end
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Input payload register: loaded on every input transfer.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_payload;
      end
   end

   // Result queue storage: the data byte goes first, the summary after it.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (byte_ok) begin
            queue_ff[wr_ff] <= data_res;
         end
         if (in_ff.last) begin
            queue_ff[wr_ff + {1'b0, byte_ok}] <= sum_res;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/b64d_checker.sv
`default_nettype none

module b64d_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire b64d_pkg::rsp_type rsp_payload
);

   // Nothing is offered in the cycle after a reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A data byte carries no status and no count, and never ends a string.
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.is_summary) |->
         (rsp_payload.status == b64d_pkg::STATUS_OK && rsp_payload.byte_count == 16'd0))
      else $error("data result with summary fields set");

   // A summary closes the string's results and carries no byte.
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.is_summary) |->
         (rsp_payload.last_result && rsp_payload.out_byte == 8'd0))
      else $error("summary without last flag or with a byte");

   // An error summary reports no bytes.
   a_error_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.is_summary
         && rsp_payload.status != b64d_pkg::STATUS_OK) |->
         (rsp_payload.byte_count == 16'd0))
      else $error("error summary with a byte count");

   // A stalled result stays on offer unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result dropped or changed");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

>>> bench/b64d_result_checker.sv
`timescale 1ns / 100ps

// Watches the character and result channels of the base64 decoder, works out
// the results due for every accepted character and compares each result
// transfer with the oldest one still due.
module b64d_result_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire b64d_pkg::req_type req_payload,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire b64d_pkg::rsp_type rsp_payload,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [15:0]       csr_data,
   output int                     fail_count,
   output int                     pending,
   output int                     checked,
   output int                     summaries
);

   // Decoder state as this checker sees it.
   logic [15:0]       capacity;
   logic [1:0]        sextet_count;
   logic [5:0]        carry_bits;
   logic              pad_flag;
   logic [1:0]        string_status;
   logic [15:0]       byte_total;
   b64d_pkg::rsp_type due_results[$];

   // Standard alphabet lookup; the top bit says whether the character is in it.
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [7:0] v;
      logic       hit;
      hit = 1'b1;
      v = 8'd0;
      if (c >= "A" && c <= "Z") begin
         v = c - "A";
      end else if (c >= "a" && c <= "z") begin
         v = c - "a" + 8'd26;
      end else if (c >= "0" && c <= "9") begin
         v = c - "0" + 8'd52;
      end else if (c == "+") begin
         v = 8'd62;
      end else if (c == "/") begin
         v = 8'd63;
      end else begin
         hit = 1'b0;
      end
      return {hit, v[5:0]};
   endfunction

   task automatic clear_string();
      sextet_count = 2'd0;
      carry_bits = 6'd0;
      pad_flag = 1'b0;
      string_status = b64d_pkg::STATUS_OK;
      byte_total = 16'd0;
   endtask

   // A byte is only emitted while the string is below its capacity.
   task automatic put_byte(input logic [7:0] value);
      b64d_pkg::rsp_type r;
      if (byte_total >= capacity) begin
         if (string_status == b64d_pkg::STATUS_OK) begin
            string_status = b64d_pkg::STATUS_OVERFLOW;
         end
      end else begin
         byte_total = byte_total + 16'd1;
         r = '0;
         r.out_byte = value;
         due_results.push_back(r);
      end
   endtask

   // Works out the results that one character transfer causes.
   task automatic predict_decode(input b64d_pkg::req_type item);
      b64d_pkg::rsp_type r;
      logic [6:0]        lookup;
      logic [5:0]        v;
      logic [7:0]        b;
      logic              have_byte;
      int                queued_n;
      queued_n = due_results.size();
      have_byte = 1'b0;
      b = 8'd0;
      if (string_status == b64d_pkg::STATUS_OK) begin
         if (item.char_code == b64d_pkg::PAD_CHAR) begin
            pad_flag = 1'b1;
         end else begin
            lookup = sextet_of(item.char_code);
            v = lookup[5:0];
            if (!lookup[6] || pad_flag) begin
               string_status = b64d_pkg::STATUS_INVALID;
            end else begin
               have_byte = (sextet_count != 2'd0);
               case (sextet_count)
                  2'd0: begin
                     carry_bits = v;
                  end
                  2'd1: begin
                     b = {carry_bits, v[5:4]};
                     carry_bits = {2'b00, v[3:0]};
                  end
                  2'd2: begin
                     b = {carry_bits[3:0], v[5:2]};
                     carry_bits = {4'b0000, v[1:0]};
                  end
                  default: begin
                     b = {carry_bits[1:0], v};
                     carry_bits = 6'd0;
                  end
               endcase
               sextet_count = sextet_count + 2'd1;
            end
         end
      end
      if (have_byte) begin
         put_byte(b);
      end

      // End of string: a lone trailing character still gives a byte.
      if (item.last) begin
         if (string_status == b64d_pkg::STATUS_OK && sextet_count == 2'd1) begin
            put_byte({carry_bits, 2'b00});
         end
         r = '0;
         r.is_summary = 1'b1;
         r.status = string_status;
         r.byte_count = (string_status == b64d_pkg::STATUS_OK) ? byte_total : 16'd0;
         due_results.push_back(r);
         clear_string();
      end

      // The newest result of this character closes its group of results.
      if (due_results.size() > queued_n) begin
         r = due_results.pop_back();
         r.last_result = 1'b1;
         due_results.push_back(r);
      end
   endtask

   task automatic check_result(input b64d_pkg::rsp_type got);
      b64d_pkg::rsp_type want;
      if (due_results.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected result: byte %02h sum %0d status %0d count %0d last %0d",
                  $time, got.out_byte, got.is_summary, got.status, got.byte_count,
                  got.last_result);
      end else begin
         want = due_results.pop_front();
         checked++;
         if (want.is_summary) begin
            summaries++;
         end
         if (got.out_byte !== want.out_byte || got.is_summary !== want.is_summary ||
             got.status !== want.status || got.byte_count !== want.byte_count ||
             got.last_result !== want.last_result) begin
            fail_count++;
            $display("%0t: expected byte %02h sum %0d status %0d count %0d last %0d",
                     $time, want.out_byte, want.is_summary, want.status,
                     want.byte_count, want.last_result);
            $display("%0t: actual   byte %02h sum %0d status %0d count %0d last %0d",
                     $time, got.out_byte, got.is_summary, got.status,
                     got.byte_count, got.last_result);
         end
      end
   endtask

   // Register writes, character transfers and result transfers, in that order.
   always @(posedge clock) begin
      if (reset) begin
         capacity = 16'hFFFF;
         clear_string();
         due_results.delete();
         fail_count = 0;
         checked = 0;
         summaries = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity = csr_data;
         end
         if (req_valid && !req_stall) begin
            predict_decode(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_payload);
         end
      end
      pending = due_results.size();
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   b64d_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   b64d_pkg::rsp_type rsp_payload;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [15:0]       csr_data = 16'd0;

   int          fail_count;
   int          pending;
   int          checked;
   int          summaries;
   int          idle_pct = 25;
   int          chars_sent = 0;
   int          strings_sent = 0;
   int          settings_done = 0;
   int          cycle_count = 0;
   logic [7:0]  text_q[$];
   logic [15:0] cap_list[7];

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   base64_stream_decoder_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   b64d_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .summaries   (summaries)
   );

   // The result side stalls at random, except in the quiet phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      if (v < 6'd26) begin
         return "A" + v;
      end else if (v < 6'd52) begin
         return "a" + (v - 6'd26);
      end else if (v < 6'd62) begin
         return "0" + (v - 6'd52);
      end else if (v == 6'd62) begin
         return "+";
      end
      return "/";
   endfunction

   // One character transfer; valid stays high afterwards so that the next
   // character can follow without a gap.
   task automatic send_char(input logic [7:0] c, input logic is_last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload.char_code = c;
      req_payload.last = is_last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) begin
         send_char(text_q[i], i == text_q.size() - 1);
      end
      text_q.delete();
      strings_sent++;
   endtask

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_q.push_back(s[i]);
      end
   endtask

   // Encodes random bytes, optionally with the padding of the final group.
   task automatic push_encoded(input int n_bytes, input logic with_pad);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      int         rem;
      for (int i = 0; i < n_bytes; i += 3) begin
         b0 = 8'($urandom_range(0, 255));
         b1 = 8'($urandom_range(0, 255));
         b2 = 8'($urandom_range(0, 255));
         rem = n_bytes - i;
         text_q.push_back(sextet_char(b0[7:2]));
         text_q.push_back(sextet_char({b0[1:0], b1[7:4]}));
         if (rem >= 2) begin
            text_q.push_back(sextet_char({b1[3:0], b2[7:6]}));
         end else if (with_pad) begin
            text_q.push_back(b64d_pkg::PAD_CHAR);
         end
         if (rem >= 3) begin
            text_q.push_back(sextet_char(b2[5:0]));
         end else if (with_pad) begin
            text_q.push_back(b64d_pkg::PAD_CHAR);
         end
      end
   endtask

   // Mostly well-formed strings, the rest broken in various ways or noise.
   task automatic make_random_text();
      int kind;
      int n_bytes;
      int pos;
      kind = $urandom_range(0, 99);
      n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 9);
      if (kind < 60) begin
         push_encoded(n_bytes, $urandom_range(0, 4) != 0);
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(b64d_pkg::PAD_CHAR);
         end
      end else if (kind < 70) begin
         // Complete groups followed by a single stray character.
         push_encoded(n_bytes - n_bytes % 3, 1'b1);
         text_q.push_back(sextet_char(6'($urandom_range(0, 63))));
         if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 2)) text_q.push_back(b64d_pkg::PAD_CHAR);
         end
      end else if (kind < 80) begin
         // Data carrying on after the padding.
         push_encoded(n_bytes - n_bytes % 3 + $urandom_range(1, 2), 1'b1);
         text_q.push_back(sextet_char(6'($urandom_range(0, 63))));
         push_encoded($urandom_range(0, 3), 1'b1);
      end else if (kind < 90) begin
         push_encoded(n_bytes + 1, 1'b1);
         pos = $urandom_range(0, text_q.size() - 1);
         text_q[pos] = 8'($urandom_range(0, 255));
      end else begin
         repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end
      if (text_q.size() == 0) begin
         text_q.push_back(b64d_pkg::PAD_CHAR);
      end
   endtask

   // Waits until every due result has arrived and the pipeline has emptied.
   task automatic settle();
      req_valid = 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      settle();
      csr_valid = 1'b1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid = 1'b0;
      settings_done++;
   endtask

   initial begin
      int phase_start;
      cap_list[0] = 16'd1;
      cap_list[1] = 16'd0;
      cap_list[2] = 16'd3;
      cap_list[3] = 16'hFFFF;
      cap_list[4] = 16'($urandom_range(4, 24));
      cap_list[5] = 16'($urandom_range(1000, 65534));
      cap_list[6] = 16'd2;

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed strings: the whole alphabet range, trailing padding, a lone
      // character, padding only, data after padding, and characters outside
      // the alphabet at both ends of the byte range.
      write_capacity(16'hFFFF);
      put_str("Az+/");
      send_text();
      put_str("aZ09==");
      send_text();
      put_str("Q");
      send_text();
      put_str("=");
      send_text();
      put_str("QU=A");
      send_text();
      text_q.push_back(8'hFF);
      text_q.push_back(8'h00);
      send_text();

      // Random strings under a range of capacities; one phase runs without
      // any idling on either side.
      for (int p = 0; p < 7; p++) begin
         write_capacity(cap_list[p]);
         idle_pct = (p == 3) ? 0 : 25;
         if (cap_list[p] <= 16'd1) begin
            put_str("QUJD");
            send_text();
         end
         phase_start = chars_sent;
         while (chars_sent - phase_start < 65) begin
            make_random_text();
            send_text();
         end
      end
      idle_pct = 25;
      settle();

      $display("tb summary: %0d characters in %0d strings under %0d capacity settings",
               chars_sent, strings_sent, settings_done);
      $display("tb summary: %0d results checked, %0d of them end-of-string summaries",
               checked, summaries);
      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/b64d_pkg.sv
rtl/core/base64_stream_decoder_core.sv
rtl/core/b64d_checker.sv
bench/b64d_result_checker.sv
bench/tb.sv
